@@ design/fcfs_pkg.sv @@
// Shared types and constants for the FCFS / round robin / MLFQ task scheduler.
`timescale 1ns / 1ps

package fcfs_pkg;

    localparam int FIELD_W = 8;

    // scheduling modes; the unused code behaves like FCFS
    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_MLFQ = 2'd2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_UNIT = 1'b1;

    localparam logic CFG_SCHED_MODE = 1'b0;
    localparam logic CFG_RR_QUANTUM = 1'b1;

    localparam logic [1:0]         SCHED_MODE_RST = MODE_FCFS;
    localparam logic [FIELD_W-1:0] RR_QUANTUM_RST = 8'd2;
    localparam logic [FIELD_W-1:0] UNITS_MAX      = 8'hFF;

    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] task_id;
        logic               unit_done;
    } t_item;

    typedef struct packed {
        logic               dispatch_valid;
        logic [FIELD_W-1:0] dispatch_task;
        logic               finish_valid;
        logic [FIELD_W-1:0] finish_task;
        logic               queue_full;
    } t_result;

    typedef struct packed {
        logic nz;
        logic full;
    } t_q_stat;

endpackage

@@ design/fcfs_level_queue.sv @@
// One priority level: circular task queue with head pointer and fill count.
`timescale 1ns / 1ps

module fcfs_level_queue #(
    parameter int DEPTH = 16,
    parameter int ID_W  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [ID_W-1:0]     i_push_data,
    input  logic                i_pop,
    output logic [ID_W-1:0]     o_head_data,
    output fcfs_pkg::t_q_stat   o_stat
);
    import fcfs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_W-1:0]  r_mem [DEPTH];
    logic [ID_W-1:0]  r_head_data;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W:0]   w_sum;
    logic [PTR_W:0]   w_wrap;
    logic [PTR_W-1:0] w_tail;

    assign w_sum  = {1'b0, r_head} + (PTR_W + 1)'(r_count);
    assign w_wrap = (w_sum >= (PTR_W + 1)'(DEPTH)) ? w_sum - (PTR_W + 1)'(DEPTH) : w_sum;
    assign w_tail = w_wrap[PTR_W-1:0];

    always_comb begin
        n_head = r_head;
        if (i_pop) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // storage plus a registered copy of the word at the next head
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[w_tail] <= i_push_data;
        end
        if (i_push && w_tail == n_head) begin
            r_head_data <= i_push_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_head_data = r_head_data;
    assign o_stat.nz   = (r_count != '0);
    assign o_stat.full = (r_count == CNT_W'(DEPTH));

endmodule

@@ design/fcfs_ctrl.sv @@
// Running-task state and the per-word push / preempt / dispatch decision.
`timescale 1ns / 1ps

module fcfs_ctrl #(
    parameter int LEVELS = 4,
    parameter int ID_W   = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_item_valid,
    input  fcfs_pkg::t_item                    i_item,
    input  logic [1:0]                         i_sched_mode,
    input  logic [fcfs_pkg::FIELD_W-1:0]       i_rr_quantum,
    input  fcfs_pkg::t_q_stat [LEVELS-1:0]     i_q_stat,
    input  logic [LEVELS-1:0][ID_W-1:0]        i_head_data,
    output logic [LEVELS-1:0]                  o_push,
    output logic [ID_W-1:0]                    o_push_data,
    output logic [LEVELS-1:0]                  o_pop,
    output fcfs_pkg::t_result                  o_result
);
    import fcfs_pkg::*;

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic               r_run_valid, n_run_valid;
    logic [ID_W-1:0]    r_run_task, n_run_task;
    logic [LVL_W-1:0]   r_run_level, n_run_level;
    logic [FIELD_W-1:0] r_units, n_units;

    logic               w_push_req;
    logic               w_push_ok;
    logic [LVL_W-1:0]   w_push_lvl;
    logic               w_full;
    logic               w_run_after;
    logic               w_fin;
    logic [FIELD_W-1:0] w_units_inc;
    logic [FIELD_W-1:0] w_quantum;
    logic [LVL_W:0]     w_lvl_inc;
    logic [LVL_W-1:0]   w_mlfq_tgt;
    logic [LEVELS-1:0]  w_avail;
    logic               w_found;
    logic [LVL_W-1:0]   w_pick_lvl;
    logic [ID_W-1:0]    w_pick_data;

    assign w_units_inc = (r_units == UNITS_MAX) ? r_units : r_units + FIELD_W'(1);
    assign w_lvl_inc   = {1'b0, r_run_level} + (LVL_W + 1)'(1);
    assign w_mlfq_tgt  = (w_lvl_inc < (LVL_W + 1)'(LEVELS)) ? w_lvl_inc[LVL_W-1:0] : r_run_level;

    // preemption, finish and push request
    always_comb begin
        w_push_req  = 1'b0;
        w_push_lvl  = '0;
        o_push_data = i_item.task_id[ID_W-1:0];
        w_run_after = r_run_valid;
        w_fin       = 1'b0;
        w_quantum   = '0;
        if (i_item_valid) begin
            if (i_item.cmd == CMD_ADD) begin
                w_push_req = 1'b1;
            end else if (r_run_valid) begin
                if (i_item.unit_done) begin
                    w_fin       = 1'b1;
                    w_run_after = 1'b0;
                end else begin
                    case (i_sched_mode)
                        MODE_RR: begin
                            w_quantum = (i_rr_quantum == '0) ? FIELD_W'(1) : i_rr_quantum;
                        end
                        MODE_MLFQ: begin
                            w_quantum  = FIELD_W'(1) << r_run_level;
                            w_push_lvl = w_mlfq_tgt;
                        end
                        default: begin
                            w_quantum = '0;
                        end
                    endcase
                    if (w_quantum != '0 && w_units_inc >= w_quantum) begin
                        w_push_req  = 1'b1;
                        o_push_data = r_run_task;
                        w_run_after = 1'b0;
                    end
                end
            end
        end
    end

    assign w_full    = w_push_req && i_q_stat[w_push_lvl].full;
    assign w_push_ok = w_push_req && !w_full;

    // highest-priority (lowest-index) non-empty level, counting this word's push; empty level bypasses
    always_comb begin
        w_found     = 1'b0;
        w_pick_lvl  = '0;
        w_pick_data = o_push_data;
        o_pop       = '0;
        o_push      = '0;
        for (int l = 0; l < LEVELS; l++) begin
            w_avail[l] = i_q_stat[l].nz || (w_push_ok && w_push_lvl == LVL_W'(l));
            o_push[l]  = w_push_ok && (w_push_lvl == LVL_W'(l));
        end
        if (i_item_valid && !w_run_after) begin
            for (int l = 0; l < LEVELS; l++) begin
                if (!w_found && w_avail[l]) begin
                    w_found     = 1'b1;
                    w_pick_lvl  = LVL_W'(l);
                    w_pick_data = i_q_stat[l].nz ? i_head_data[l] : o_push_data;
                    o_pop[l]    = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_run_valid = w_run_after;
        n_run_task  = r_run_task;
        n_run_level = r_run_level;
        n_units     = r_units;
        if (i_item.cmd == CMD_UNIT && r_run_valid) begin
            n_units = w_units_inc;
        end
        if (w_found) begin
            n_run_valid = 1'b1;
            n_run_task  = w_pick_data;
            n_run_level = w_pick_lvl;
            n_units     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_run_level <= '0;
            r_units     <= '0;
        end else if (i_item_valid) begin
            r_run_valid <= n_run_valid;
            r_run_task  <= n_run_task;
            r_run_level <= n_run_level;
            r_units     <= n_units;
        end
    end

    assign o_result.dispatch_valid = w_found;
    assign o_result.dispatch_task  = n_run_valid ? FIELD_W'(n_run_task) : '0;
    assign o_result.finish_valid   = w_fin;
    assign o_result.finish_task    = w_fin ? FIELD_W'(r_run_task) : '0;
    assign o_result.queue_full     = w_full;

endmodule

@@ design/fcfs_rr_mlfq_task_scheduler_unit.sv @@
// Top level of the FCFS / round robin / MLFQ task scheduler.
`timescale 1ns / 1ps

// One word per cycle in, one result per word out. A word taken on start (busy
// low) is registered, then decided in a single pass over the level queues and
// the running-task state; its result is registered and put on the o_ ports
// with o_strobe, and is held for one cycle only, since the receiver cannot
// stall. Busy is high during reset and in the cycle after it. Queue storage
// needs no clearing pass. Write configuration only while no word is in flight.
module fcfs_rr_mlfq_task_scheduler_unit #(
    parameter int LEVELS       = 4,
    parameter int QUEUE_DEPTH  = 16,
    parameter int TASK_ID_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [fcfs_pkg::FIELD_W-1:0] i_task_id,
    input  logic                         i_unit_done,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [fcfs_pkg::FIELD_W-1:0] i_cfg_data,
    output logic                         o_strobe,
    output logic                         o_dispatch_valid,
    output logic [fcfs_pkg::FIELD_W-1:0] o_dispatch_task,
    output logic                         o_finish_valid,
    output logic [fcfs_pkg::FIELD_W-1:0] o_finish_task,
    output logic                         o_queue_full
);
    import fcfs_pkg::*;

    localparam int ID_W = (TASK_ID_BITS < FIELD_W) ? TASK_ID_BITS : FIELD_W;

    logic               r_busy;
    logic               r_in_valid;
    t_item              r_item;
    logic [1:0]         r_sched_mode;
    logic [FIELD_W-1:0] r_rr_quantum;
    logic               r_strobe;
    t_result            r_result;

    t_q_stat [LEVELS-1:0]       w_q_stat;
    logic [LEVELS-1:0][ID_W-1:0] w_head_data;
    logic [LEVELS-1:0]          w_push;
    logic [LEVELS-1:0]          w_pop;
    logic [ID_W-1:0]            w_push_data;
    t_result                    w_result;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_in_valid   <= 1'b0;
            r_strobe     <= 1'b0;
            r_sched_mode <= SCHED_MODE_RST;
            r_rr_quantum <= RR_QUANTUM_RST;
        end else begin
            r_busy     <= 1'b0;
            r_in_valid <= start && !r_busy;
            r_strobe   <= r_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCHED_MODE: r_sched_mode <= i_cfg_data[1:0];
                    CFG_RR_QUANTUM: r_rr_quantum <= i_cfg_data;
                    default:        r_sched_mode <= r_sched_mode;
                endcase
            end
        end
    end

    // payload words
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_item.cmd       <= i_cmd;
            r_item.task_id   <= i_task_id;
            r_item.unit_done <= i_unit_done;
        end
        r_result <= w_result;
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_level
        fcfs_level_queue #(
            .DEPTH (QUEUE_DEPTH),
            .ID_W  (ID_W)
        ) u_queue (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_push      (w_push[g]),
            .i_push_data (w_push_data),
            .i_pop       (w_pop[g]),
            .o_head_data (w_head_data[g]),
            .o_stat      (w_q_stat[g])
        );
    end

    fcfs_ctrl #(
        .LEVELS (LEVELS),
        .ID_W   (ID_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_item),
        .i_sched_mode (r_sched_mode),
        .i_rr_quantum (r_rr_quantum),
        .i_q_stat     (w_q_stat),
        .i_head_data  (w_head_data),
        .o_push       (w_push),
        .o_push_data  (w_push_data),
        .o_pop        (w_pop),
        .o_result     (w_result)
    );

    assign o_strobe         = r_strobe;
    assign o_dispatch_valid = r_result.dispatch_valid;
    assign o_dispatch_task  = r_result.dispatch_task;
    assign o_finish_valid   = r_result.finish_valid;
    assign o_finish_task    = r_result.finish_task;
    assign o_queue_full     = r_result.queue_full;

endmodule
